@@ rtl/uptw_pkg.sv @@
// ----------------------------------------------------------------------------
// uptw_pkg
// shared types and constants of the user page-table walker
// ----------------------------------------------------------------------------
package uptw_pkg;

  // controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_WALK,
    ST_RESP
  } uptw_state_t;

  // item modes
  localparam logic [2:0] MODE_WRITE  = 3'd0;
  localparam logic [2:0] MODE_CHECK  = 3'd1;
  localparam logic [2:0] MODE_LOOKUP = 3'd2;
  localparam logic [2:0] MODE_MAP    = 3'd3;
  localparam logic [2:0] MODE_UNMAP  = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_ROOT        = 2'd0;
  localparam logic [1:0] CFG_WINDOW_BASE = 2'd1;
  localparam logic [1:0] CFG_WINDOW_SIZE = 2'd2;

  // table entry bits
  localparam int ENT_PRESENT_BIT = 0;
  localparam int ENT_WRITE_BIT   = 1;
  localparam int ENT_USER_BIT    = 2;
  localparam int ENT_LARGE_BIT   = 7;

  localparam logic [63:0] ENT_PRESENT = 64'h001;
  localparam logic [63:0] ENT_WRITE   = 64'h002;
  localparam logic [63:0] ENT_USER    = 64'h004;

  // entry index of a virtual address at walk level lvl (0 is the top level)
  function automatic logic [8:0] level_index(input logic [47:0] va, input logic [1:0] lvl);
    logic [8:0] idx;
    case (lvl)
      2'd0: idx = va[47:39];
      2'd1: idx = va[38:30];
      2'd2: idx = va[29:21];
      default: idx = va[20:12];
    endcase
    return idx;
  endfunction

endpackage

@@ rtl/user_page_table_walker_top.sv @@
// ----------------------------------------------------------------------------
// user_page_table_walker_top
// four-level user page-table walker over an internal table word store
// ----------------------------------------------------------------------------
// The block holds STORE_WORDS 64-bit table words in one single-port store and
// serves one item at a time. After reset a clearing pass writes zero to every
// store word, one word per cycle, and no item is taken until it has ended
// (configuration writes are taken throughout). The decode state then does a
// word write, catches a failure before the walk or issues the top-level read;
// the walk state reads one level after another, one to four table reads in
// all, and the response state loads the result. The walk is bound by the chain
// of dependent table reads through the one store port: each level's address
// comes from the entry read at the level above. Map and unmap write the
// page-table entry in place of its read. A finished result sits in the output
// register until its transfer; the next item can be taken meanwhile.
// ----------------------------------------------------------------------------
module user_page_table_walker_top
  import uptw_pkg::*;
#(
  parameter int STORE_WORDS = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  // item input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_mode,
  input  logic [47:0] in_virtual_address,
  input  logic [11:0] in_word_index,
  input  logic [63:0] in_entry_value,
  input  logic [51:0] in_frame_address,
  input  logic        in_writable,
  // result output
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_ok,
  output logic [51:0] out_frame_out,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int AW = $clog2(STORE_WORDS);
  localparam logic [AW-1:0] LAST_WORD = AW'(STORE_WORDS - 1);
  localparam logic [48:0]   WORDS_W   = 49'(STORE_WORDS);

  // controller state
  uptw_state_t   state_r, state_nxt;
  logic [1:0]    lvl_r, lvl_nxt;        // level of the entry now in the read register
  logic [AW-1:0] clr_addr_r;

  // configuration registers
  logic [51:0] root_r;
  logic [47:0] win_base_r;
  logic [48:0] win_size_r;

  // latched item
  logic [2:0]  mode_r;
  logic [47:0] va_r;
  logic [11:0] wi_r;
  logic [63:0] val_r;
  logic [51:0] frame_r;
  logic        wr_r;
  logic        win_r;        // address inside the user window
  logic        va_align_r;
  logic        frame_good_r; // non-zero and page aligned

  // result being built, output register
  logic        res_ok_r, res_ok_nxt;
  logic [51:0] res_frame_r, res_frame_nxt;
  logic        out_valid_r;
  logic        out_ok_r;
  logic [51:0] out_frame_r;

  // store port
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [63:0]   mem_wdata;
  logic [63:0]   rd_data;

  logic walk_done;

  uptw_store #(
    .STORE_WORDS(STORE_WORDS)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(rd_data)
  );

  // handshake
  logic in_xfer, out_load;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_load  = (state_r == ST_RESP) && (!out_valid_r || !out_stall);

  // user window check on the incoming address
  logic [47:0] win_diff;
  logic        win_in;
  assign win_diff = in_virtual_address - win_base_r;
  assign win_in   = (in_virtual_address >= win_base_r) && ({1'b0, win_diff} < win_size_r);

  // slot of the next table entry: the table base comes from the root in the
  // decode state and from the entry just read in the walk state
  logic [51:0] tab_addr;
  logic [1:0]  idx_lvl;
  logic [48:0] slot_w;
  logic        slot_in;
  assign tab_addr = (state_r == ST_DECODE) ? root_r : rd_data[51:0];
  assign idx_lvl  = (state_r == ST_DECODE) ? 2'd0 : lvl_r + 2'd1;
  assign slot_w   = {tab_addr[51:12], level_index(va_r, idx_lvl)};
  assign slot_in  = slot_w < WORDS_W;

  // word write target
  logic [48:0] wi_w;
  logic        wi_in;
  assign wi_w  = 49'(wi_r);
  assign wi_in = wi_w < WORDS_W;

  // checks before any table read
  logic pre_ok;
  always_comb begin
    case (mode_r)
      MODE_CHECK, MODE_LOOKUP: pre_ok = win_r;
      MODE_MAP:                pre_ok = win_r && va_align_r && frame_good_r;
      MODE_UNMAP:              pre_ok = win_r && va_align_r;
      default:                 pre_ok = 1'b0;
    endcase
  end

  // entry just read
  logic ent_present, ent_user, ent_large, lvl_ok;
  assign ent_present = rd_data[ENT_PRESENT_BIT];
  assign ent_user    = rd_data[ENT_USER_BIT];
  assign ent_large   = rd_data[ENT_LARGE_BIT];
  // access checks want user at every level, the other walks only present
  assign lvl_ok      = ent_present && (ent_user || (mode_r != MODE_CHECK));

  // new page-table entry for map, zero for unmap
  logic [63:0] map_word;
  assign map_word = (mode_r == MODE_MAP) ?
                    (64'(frame_r) | ENT_PRESENT | ENT_USER | (wr_r ? ENT_WRITE : 64'd0)) :
                    64'd0;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_addr_r == LAST_WORD) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_xfer) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        if (walk_done) state_nxt = ST_RESP;
        else state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (walk_done) state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // store port, walk steps and result
  always_comb begin
    mem_we        = 1'b0;
    mem_addr      = clr_addr_r;
    mem_wdata     = 64'd0;
    walk_done     = 1'b0;
    lvl_nxt       = lvl_r;
    res_ok_nxt    = res_ok_r;
    res_frame_nxt = res_frame_r;
    case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_DECODE: begin
        res_ok_nxt    = 1'b0;
        res_frame_nxt = '0;
        lvl_nxt       = 2'd0;
        if (mode_r == MODE_WRITE) begin
          walk_done = 1'b1;
          mem_addr  = wi_w[AW-1:0];
          mem_wdata = val_r;
          if (wi_in) begin
            mem_we     = 1'b1;
            res_ok_nxt = 1'b1;
          end
        end else if (pre_ok && slot_in) begin
          mem_addr = slot_w[AW-1:0];   // top-level read
        end else begin
          walk_done = 1'b1;
        end
      end
      ST_WALK: begin
        mem_addr  = slot_w[AW-1:0];
        mem_wdata = map_word;
        if (!lvl_ok) begin
          walk_done = 1'b1;
        end else if (lvl_r == 2'd3) begin
          // final entry of a check or lookup
          walk_done  = 1'b1;
          res_ok_nxt = 1'b1;
          if (mode_r == MODE_LOOKUP) res_frame_nxt = {rd_data[51:12], 12'd0};
        end else if ((lvl_r == 2'd2) && ent_large) begin
          // 2 MB leaf: good for an access check, a failure otherwise
          walk_done  = 1'b1;
          res_ok_nxt = (mode_r == MODE_CHECK);
        end else if (!slot_in) begin
          walk_done = 1'b1;
        end else if ((lvl_r == 2'd2) && ((mode_r == MODE_MAP) || (mode_r == MODE_UNMAP))) begin
          walk_done  = 1'b1;
          mem_we     = 1'b1;
          res_ok_nxt = 1'b1;
        end else begin
          lvl_nxt = lvl_r + 2'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      lvl_r       <= 2'd0;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      lvl_r   <= lvl_nxt;
      if (state_r == ST_CLEAR) clr_addr_r <= clr_addr_r + 1'b1;
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (out_load) out_valid_r <= 1'b1;
    end
  end

  // configuration, to be only written while idle: a rule for the user, not enforced by the block
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r     <= 52'd0;
      win_base_r <= 48'h00_0001_000000;
      win_size_r <= 49'h0_0000_0040_0000;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ROOT:        root_r     <= cfg_data[51:0];
        CFG_WINDOW_BASE: win_base_r <= cfg_data[47:0];
        CFG_WINDOW_SIZE: win_size_r <= cfg_data[48:0];
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mode_r       <= in_mode;
      va_r         <= in_virtual_address;
      wi_r         <= in_word_index;
      val_r        <= in_entry_value;
      frame_r      <= in_frame_address;
      wr_r         <= in_writable;
      win_r        <= win_in;
      va_align_r   <= (in_virtual_address[11:0] == 12'd0);
      frame_good_r <= (in_frame_address != 52'd0) && (in_frame_address[11:0] == 12'd0);
    end
    res_ok_r    <= res_ok_nxt;
    res_frame_r <= res_frame_nxt;
    if (out_load) begin
      out_ok_r    <= res_ok_r;
      out_frame_r <= res_frame_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_ok        = out_ok_r;
  assign out_frame_out = out_frame_r;

  // a finished result always reaches the output register
  a_resp_loads: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_valid_r && (state_r == ST_IDLE)))
    else $error("result not loaded after response state");

  // a frame is only reported on success
  a_frame_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_frame_r != 52'd0)) |-> out_ok_r)
    else $error("frame reported with failure");

  // the store is written only by clearing, word writes and map or unmap
  a_store_write: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> ((state_r == ST_CLEAR) || (state_r == ST_DECODE) || (state_r == ST_WALK)))
    else $error("store written outside clear or walk");

  // only the walking modes reach the table walk
  a_walk_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> ((mode_r == MODE_CHECK) || (mode_r == MODE_LOOKUP) ||
                              (mode_r == MODE_MAP) || (mode_r == MODE_UNMAP)))
    else $error("walk entered with a non-walk mode");

endmodule

@@ rtl/uptw_store.sv @@
// ----------------------------------------------------------------------------
// uptw_store
// single-port table word store, registered read data
// ----------------------------------------------------------------------------
module uptw_store #(
  parameter int STORE_WORDS = 4096
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [$clog2(STORE_WORDS)-1:0] addr,
  input  logic [63:0]                    wdata,
  output logic [63:0]                    rdata
);

  logic [63:0] mem [STORE_WORDS];
  logic [63:0] rdata_r;

  // a write cycle leaves the read register holding its last value
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ tb/tb_user_page_table_walker_top.sv @@
// ----------------------------------------------------------------------------
// tb_user_page_table_walker_top
// self-checking bench for the four-level user page-table walker
// ----------------------------------------------------------------------------
// Keeps a shadow copy of the table word store and the three configuration registers,
// works out the answer of every item as it is taken and compares each result
// transfer against the oldest outstanding answer. Directed items cover the
// cleared store, a hand-built walk with map, lookup, check and unmap, the
// alignment and zero-frame checks, the 2 MB leaf and walks that leave the
// store. Window and root extremes follow, then random phases that build page
// table paths with mode 0 writes and exercise them, mixed with noise items.
// Both handshakes see random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_user_page_table_walker_top;
  timeunit 1ns;
  timeprecision 1ps;

  import uptw_pkg::*;

  localparam int unsigned STORE_WORDS  = 4096;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int          RANDOM_ITEMS = 1200;

  // address field of a table entry and the 2 MB leaf flag
  localparam logic [63:0] ADDR_MASK  = 64'h000F_FFFF_FFFF_F000;
  localparam logic [63:0] LARGE_FLAG = 64'h1 << ENT_LARGE_BIT;

  // modes the block does not implement, answered with ok low
  localparam logic [2:0] MODE_UNUSED_5 = 3'd5;
  localparam logic [2:0] MODE_UNUSED_7 = 3'd7;

  // home address of the default window: indexes 0, 0, 8, 0
  localparam logic [47:0] VA_HOME = 48'h0000_0100_0000;

  typedef struct {
    logic [2:0]  mode;
    logic [47:0] va;
    logic [11:0] word_index;
    logic [63:0] entry_value;
    logic [51:0] frame;
    logic        writable;
  } walk_item_t;

  typedef struct {
    logic        ok;
    logic [51:0] frame;
  } walk_result_t;

  // ---------------------------------------------------------------------------
  // clock, reset and block ports
  // ---------------------------------------------------------------------------
  logic        clk;
  logic        rst_n              = 1'b0;
  logic        in_valid           = 1'b0;
  logic        in_stall;
  logic [2:0]  in_mode            = MODE_WRITE;
  logic [47:0] in_virtual_address = '0;
  logic [11:0] in_word_index      = '0;
  logic [63:0] in_entry_value     = '0;
  logic [51:0] in_frame_address   = '0;
  logic        in_writable        = 1'b0;
  logic        out_valid;
  logic        out_stall          = 1'b0;
  logic        out_ok;
  logic [51:0] out_frame_out;
  logic        cfg_valid          = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index          = CFG_ROOT;
  logic [63:0] cfg_data           = '0;

  user_page_table_walker_top #(
    .STORE_WORDS(STORE_WORDS)
  ) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_mode           (in_mode),
    .in_virtual_address(in_virtual_address),
    .in_word_index     (in_word_index),
    .in_entry_value    (in_entry_value),
    .in_frame_address  (in_frame_address),
    .in_writable       (in_writable),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_ok            (out_ok),
    .out_frame_out     (out_frame_out),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // shadow state: table words and configuration registers as the block should hold
  // them, updated at the edge where an item or a register write transfers
  // ---------------------------------------------------------------------------
  logic [63:0] table_mem [STORE_WORDS];
  logic [51:0] root_reg;
  logic [47:0] win_base;
  logic [48:0] win_size;

  walk_result_t expected_walks[$];   // answers still owed by the block
  walk_item_t   batch[$];            // items waiting to be sent

  int unsigned mismatch_count;
  int unsigned result_count;
  int unsigned cycle_count;
  bit          sender_gaps_on;
  bit          sink_stalls_on;
  int          stall_left;

  initial begin
    foreach (table_mem[i]) table_mem[i] = '0;
    root_reg       = '0;
    win_base       = 48'h0000_0100_0000;
    win_size       = 49'h0_0000_0040_0000;
    mismatch_count = 0;
    result_count   = 0;
    cycle_count    = 0;
    sender_gaps_on = 1'b1;
    sink_stalls_on = 1'b1;
    stall_left     = 0;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // 9-bit entry index of va at walk level lvl, 0 being the top level
  function automatic logic [8:0] va_index(input logic [47:0] va, input int lvl);
    logic [47:0] sh;
    sh = va >> (39 - 9 * lvl);
    return sh[8:0];
  endfunction

  // store word of entry idx in the table named by bits 51..12 of tab
  function automatic bit store_word_of(input logic [63:0] tab, input logic [8:0] idx,
                                       output int unsigned word);
    logic [63:0] w;
    w    = ((tab & ADDR_MASK) >> 3) + 64'(idx);
    word = w[31:0];
    return w < STORE_WORDS;
  endfunction

  function automatic bit window_hit(input logic [47:0] va);
    logic [48:0] off;
    if (va < win_base) return 1'b0;
    off = {1'b0, va} - {1'b0, win_base};
    return off < win_size;
  endfunction

  // walk to the page-table entry of va: top two levels present, directory
  // present and not a 2 MB leaf, user bits ignored
  function automatic bit pte_word(input logic [47:0] va, output int unsigned word);
    logic [63:0] ent;
    int unsigned w;
    ent = {12'd0, root_reg};
    for (int lvl = 0; lvl < 3; lvl++) begin
      if (!store_word_of(ent, va_index(va, lvl), w)) return 1'b0;
      ent = table_mem[w];
      if (!ent[ENT_PRESENT_BIT]) return 1'b0;
    end
    if (ent[ENT_LARGE_BIT]) return 1'b0;
    return store_word_of(ent, va_index(va, 3), word);
  endfunction

  // user access: every level present and user, 2 MB leaf taken at directory
  function automatic bit user_reach(input logic [47:0] va);
    logic [63:0] ent;
    int unsigned w;
    if (!window_hit(va)) return 1'b0;
    ent = {12'd0, root_reg};
    for (int lvl = 0; lvl < 4; lvl++) begin
      if (!store_word_of(ent, va_index(va, lvl), w)) return 1'b0;
      ent = table_mem[w];
      if (!(ent[ENT_PRESENT_BIT] && ent[ENT_USER_BIT])) return 1'b0;
      if (lvl == 2 && ent[ENT_LARGE_BIT]) return 1'b1;
    end
    return 1'b1;
  endfunction

  // answer of one item, applying its store update to the shadow copy
  function automatic walk_result_t walk_outcome(input walk_item_t it);
    walk_result_t r;
    int unsigned  w;
    bit           page_aligned;
    r.ok         = 1'b0;
    r.frame      = '0;
    page_aligned = (it.va[11:0] == 12'd0);
    case (it.mode)
      MODE_WRITE: begin
        if (it.word_index < STORE_WORDS) begin
          table_mem[it.word_index] = it.entry_value;
          r.ok = 1'b1;
        end
      end
      MODE_CHECK: r.ok = user_reach(it.va);
      MODE_LOOKUP: begin
        if (window_hit(it.va) && pte_word(it.va, w) && table_mem[w][ENT_PRESENT_BIT]) begin
          r.ok    = 1'b1;
          r.frame = table_mem[w][51:0] & ADDR_MASK[51:0];
        end
      end
      MODE_MAP: begin
        if (window_hit(it.va) && page_aligned && it.frame != '0 && it.frame[11:0] == 12'd0 &&
            pte_word(it.va, w)) begin
          table_mem[w] = {12'd0, it.frame} | ENT_PRESENT | ENT_USER |
                         (it.writable ? ENT_WRITE : 64'd0);
          r.ok = 1'b1;
        end
      end
      MODE_UNMAP: begin
        if (window_hit(it.va) && page_aligned && pte_word(it.va, w)) begin
          table_mem[w] = '0;
          r.ok = 1'b1;
        end
      end
      default: r.ok = 1'b0;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // idle length: mostly short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 2);
    if (r < 92) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic int sender_gap();
    if (!sender_gaps_on || $urandom_range(0, 1) == 0) return 0;
    return pick_gap();
  endfunction

  function automatic walk_item_t mk_item(input logic [2:0] mode, input logic [47:0] va,
                                         input logic [11:0] wi, input logic [63:0] val,
                                         input logic [51:0] frame, input logic wr);
    walk_item_t it;
    it.mode        = mode;
    it.va          = va;
    it.word_index  = wi;
    it.entry_value = val;
    it.frame       = frame;
    it.writable    = wr;
    return it;
  endfunction

  function automatic walk_item_t noise_item();
    return mk_item(3'($urandom), 48'(rand64()), 12'($urandom), rand64(), 52'(rand64()),
                   1'($urandom));
  endfunction

  // the window base plus a random offset below its size, or anywhere when the window is empty
  function automatic logic [47:0] pick_window_va();
    logic [63:0] off;
    if (win_size == '0) return 48'(rand64());
    off = rand64() % {15'd0, win_size};
    return win_base + off[47:0];
  endfunction

  // table entry: mostly a present user pointer to one of the eight pages the
  // store holds, sometimes missing a flag, pointing out of the store or with
  // the ignored bits set
  function automatic logic [63:0] random_table_entry(input bit is_dir);
    logic [63:0] e;
    if ($urandom_range(0, 31) == 0) e = rand64() & ADDR_MASK;
    else e = 64'($urandom_range(0, 7)) << 12;
    if ($urandom_range(0, 15) != 0) e |= ENT_PRESENT;
    if ($urandom_range(0, 9) != 0) e |= ENT_USER;
    if ($urandom_range(0, 1) != 0) e |= ENT_WRITE;
    if (is_dir && $urandom_range(0, 7) == 0) e |= LARGE_FLAG;
    if ($urandom_range(0, 3) == 0)
      e |= rand64() & ~(ADDR_MASK | ENT_PRESENT | ENT_USER | LARGE_FLAG);
    return e;
  endfunction

  // mode 0 writes that lay the top, pointer and directory entries for va
  function automatic void queue_walk_setup(input logic [47:0] va);
    logic [63:0] tab;
    logic [63:0] ent;
    int unsigned w;
    tab = {12'd0, root_reg};
    for (int lvl = 0; lvl < 3; lvl++) begin
      ent = random_table_entry(lvl == 2);
      // an occasional level is left as the store already has it
      if (store_word_of(tab, va_index(va, lvl), w) && $urandom_range(0, 9) != 0)
        batch.push_back(mk_item(MODE_WRITE, 48'(rand64()), 12'(w), ent, 52'(rand64()),
                                1'($urandom)));
      tab = ent;
    end
  endfunction

  // operations on va and its neighbours under the same page table
  function automatic void queue_page_ops(input logic [47:0] va, input int count);
    logic [47:0] addr;
    logic [51:0] frame;
    int          pick;
    for (int n = 0; n < count; n++) begin
      addr = va;
      if ($urandom_range(0, 2) == 0) addr[20:12] = 9'($urandom);
      if ($urandom_range(0, 9) == 0) addr[11:0] = 12'($urandom);
      frame = 52'(rand64()) & ~52'hFFF;
      pick  = $urandom_range(0, 11);
      if (pick == 0) frame = '0;
      else if (pick == 1) frame[11:0] = 12'($urandom);
      pick = $urandom_range(0, 9);
      if (pick < 3)
        batch.push_back(mk_item(MODE_MAP, addr, 12'($urandom), rand64(), frame, 1'($urandom)));
      else if (pick < 6)
        batch.push_back(mk_item(MODE_LOOKUP, addr, 12'($urandom), rand64(), frame,
                                1'($urandom)));
      else if (pick < 8)
        batch.push_back(mk_item(MODE_CHECK, addr, 12'($urandom), rand64(), frame,
                                1'($urandom)));
      else if (pick < 9)
        batch.push_back(mk_item(MODE_UNMAP, addr, 12'($urandom), rand64(), frame,
                                1'($urandom)));
      else
        batch.push_back(noise_item());
    end
  endfunction

  // ---------------------------------------------------------------------------
  // item sender: one transfer per queued item, answer predicted at the edge
  // where it is taken; valid drops only on a gap or after the last item, and
  // the last item is followed by an idle edge
  // ---------------------------------------------------------------------------
  task automatic send_batch();
    walk_item_t it;
    int         gap;
    while (batch.size() != 0) begin
      it = batch.pop_front();
      in_valid           <= 1'b1;
      in_mode            <= it.mode;
      in_virtual_address <= it.va;
      in_word_index      <= it.word_index;
      in_entry_value     <= it.entry_value;
      in_frame_address   <= it.frame;
      in_writable        <= it.writable;
      do @(posedge clk); while (in_stall !== 1'b0);
      expected_walks.push_back(walk_outcome(it));
      gap = sender_gap();
      if (batch.size() == 0 && gap == 0) gap = 1;
      if (batch.size() == 0 || gap > 0) in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    while (expected_walks.size() != 0) @(posedge clk);
  endtask

  // register writes only once every owed result has come back
  task automatic program_regs(input logic [51:0] root, input logic [47:0] base,
                              input logic [48:0] size);
    logic [1:0]  which [3];
    logic [63:0] value [3];
    which = '{CFG_ROOT, CFG_WINDOW_BASE, CFG_WINDOW_SIZE};
    // bits above each register's width are noise the block drops
    value = '{{12'($urandom), root}, {16'($urandom), base}, {15'($urandom), size}};
    wait_idle();
    for (int k = 0; k < 3; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= which[k];
      cfg_data  <= value[k];
      do @(posedge clk); while (cfg_ready !== 1'b1);
      case (which[k])
        CFG_ROOT:        root_reg = value[k][51:0];
        CFG_WINDOW_BASE: win_base = value[k][47:0];
        CFG_WINDOW_SIZE: win_size = value[k][48:0];
        default:         root_reg = root_reg;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stall, then compare each transfer with the oldest
  // owed answer
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : sink_pacing
    if (stall_left > 0) begin
      stall_left--;
    end else if (sink_stalls_on && $urandom_range(0, 3) == 0) begin
      stall_left = pick_gap();
    end
    out_stall <= (stall_left != 0);
  end

  always @(posedge clk) begin : result_check
    walk_result_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      result_count++;
      if (expected_walks.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("[%0t] result %0d arrived with nothing owed: ok=%0b frame=%h",
                   $realtime, result_count, out_ok, out_frame_out);
      end else begin
        want = expected_walks.pop_front();
        if (out_ok !== want.ok || out_frame_out !== want.frame) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("[%0t] result %0d mismatch: ok exp %0b got %0b, frame exp %h got %h",
                     $realtime, result_count, want.ok, out_ok, want.frame, out_frame_out);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // cleared store: every walk fails, unused modes fail, out-of-window fails
  task automatic test_empty_store();
    batch.push_back(mk_item(MODE_LOOKUP, VA_HOME, '0, '0, '0, 1'b0));
    batch.push_back(mk_item(MODE_CHECK, VA_HOME, '0, '0, '0, 1'b0));
    batch.push_back(mk_item(MODE_MAP, VA_HOME, '0, '0, 52'h5000, 1'b1));
    batch.push_back(mk_item(MODE_UNMAP, VA_HOME, '0, '0, '0, 1'b0));
    batch.push_back(mk_item(MODE_CHECK, 48'h0, '0, '0, '0, 1'b0));
    // unused modes with every field at its top value
    batch.push_back(mk_item(MODE_UNUSED_5, '1, '1, '1, '1, 1'b1));
    batch.push_back(mk_item(MODE_UNUSED_7, '1, '1, '1, '1, 1'b1));
    send_batch();
  endtask

  // hand-built walk rooted at address zero: pointer table on page 1,
  // directory on page 2, page table on page 3
  task automatic test_basic_walk();
    batch.push_back(mk_item(MODE_WRITE, '0, 12'd0, 64'h1000 | ENT_PRESENT | ENT_USER | ENT_WRITE,
                            '0, 1'b0));
    batch.push_back(mk_item(MODE_WRITE, '0, 12'd512, 64'h2000 | ENT_PRESENT | ENT_USER, '0, 1'b0));
    batch.push_back(mk_item(MODE_WRITE, '0, 12'd1032, 64'h3000 | ENT_PRESENT | ENT_USER, '0,
                            1'b0));
    // map the top frame, then read it back both ways
    batch.push_back(mk_item(MODE_MAP, VA_HOME, '0, '0, 52'hF_FFFF_FFFF_F000, 1'b1));
    batch.push_back(mk_item(MODE_LOOKUP, VA_HOME, '0, '0, '0, 1'b0));
    batch.push_back(mk_item(MODE_CHECK, VA_HOME, '0, '0, '0, 1'b0));
    // misaligned page, zero frame, misaligned frame, then a good map, a check, unmap and lookup
    batch.push_back(mk_item(MODE_MAP, VA_HOME + 48'd1, '0, '0, 52'h4000, 1'b0));
    batch.push_back(mk_item(MODE_MAP, VA_HOME + 48'h1000, '0, '0, '0, 1'b0));
    batch.push_back(mk_item(MODE_MAP, VA_HOME + 48'h1000, '0, '0, 52'h1234, 1'b0));
    batch.push_back(mk_item(MODE_MAP, VA_HOME + 48'h1000, '0, '0, 52'h7000, 1'b0));
    batch.push_back(mk_item(MODE_CHECK, VA_HOME + 48'h1FFF, '0, '0, '0, 1'b0));
    batch.push_back(mk_item(MODE_UNMAP, VA_HOME, '0, '0, '0, 1'b0));
    batch.push_back(mk_item(MODE_LOOKUP, VA_HOME, '0, '0, '0, 1'b0));
    // all-ones directory entry: a present user 2 MB leaf, so check passes
    // while lookup refuses it
    batch.push_back(mk_item(MODE_WRITE, '0, 12'd1033, '1, '0, 1'b0));
    batch.push_back(mk_item(MODE_CHECK, VA_HOME + 48'h20_0000, '0, '0, '0, 1'b0));
    batch.push_back(mk_item(MODE_LOOKUP, VA_HOME + 48'h20_0000, '0, '0, '0, 1'b0));
    // page table moved past the end of the store
    batch.push_back(mk_item(MODE_WRITE, '0, 12'd1032, 64'h8000 | ENT_PRESENT | ENT_USER, '0,
                            1'b0));
    batch.push_back(mk_item(MODE_LOOKUP, VA_HOME + 48'h1000, '0, '0, '0, 1'b0));
    batch.push_back(mk_item(MODE_WRITE, '0, 12'hFFF, '0, '0, 1'b0));
    send_batch();
  endtask

  // one register setting, a path built under it and a few probes
  task automatic probe_window(input logic [51:0] root, input logic [47:0] base,
                              input logic [48:0] size);
    logic [47:0] va;
    program_regs(root, base, size);
    va       = pick_window_va();
    va[11:0] = 12'd0;
    queue_walk_setup(va);
    queue_page_ops(va, 4);
    batch.push_back(mk_item(MODE_CHECK, 48'hFFFF_FFFF_FFFF, '0, '0, '0, 1'b0));
    batch.push_back(mk_item(MODE_LOOKUP, 48'h0, '0, '0, '0, 1'b0));
    send_batch();
  endtask

  task automatic test_window_extremes();
    // whole address space, root at zero
    probe_window(52'h0, 48'h0, 49'h1_0000_0000_0000);
    // root far beyond the store, window of one byte at the top
    probe_window(52'hF_FFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 49'h1);
    // root on the last page with ignored low bits, window running off the top
    probe_window(52'h7ABC, 48'hFFFF_FFFF_F000, 49'h1_0000_0000_0000);
    // empty window
    probe_window(52'h3000, 48'h0, 49'h0);
  endtask

  // random phases: a fresh register setting, then well-formed walk sequences
  // with random content plus some noise
  task automatic test_random_traffic();
    int          sent;
    int          pick;
    logic [47:0] va;
    logic [51:0] root;
    logic [47:0] base;
    logic [48:0] size;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) root = 52'(rand64());
      else root = {37'd0, 3'($urandom_range(0, 7)), 12'($urandom)};
      pick = $urandom_range(0, 9);
      if (pick == 0) base = '0;
      else if (pick == 1) base = '1;
      else base = 48'(rand64()) & ~48'hFFF;
      pick = $urandom_range(0, 15);
      if (pick == 0) size = '0;
      else if (pick == 1) size = 49'h1_0000_0000_0000;
      else if (pick == 2) size = 49'(rand64());
      else size = 49'($urandom_range(1, 2048)) << 12;
      program_regs(root, base, size);
      // some phases run without idling on one side or the other
      sender_gaps_on = ($urandom_range(0, 3) != 0);
      sink_stalls_on = ($urandom_range(0, 3) != 0);
      repeat (12) begin
        va = pick_window_va();
        if ($urandom_range(0, 3) != 0) va[11:0] = 12'd0;
        queue_walk_setup(va);
        queue_page_ops(va, $urandom_range(3, 8));
        if ($urandom_range(0, 4) == 0) batch.push_back(noise_item());
      end
      sent += batch.size();
      send_batch();
    end
  endtask

  // ---------------------------------------------------------------------------
  // run control
  // ---------------------------------------------------------------------------
  initial begin : run
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    // the block clears its store before it takes items; the sender waits
    test_empty_store();
    test_basic_walk();
    test_window_extremes();
    test_random_traffic();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // hang guard
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[%0t] cycle limit reached with %0d results owed", $realtime,
             expected_walks.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/uptw_pkg.sv
rtl/uptw_store.sv
rtl/user_page_table_walker_top.sv
tb/tb_user_page_table_walker_top.sv
